// File: src/rrwt_pkg.sv
`timescale 1ns / 1ps

package rrwt_pkg;

   localparam int BURST_W = 16;
   localparam int OUT_W   = 20;
   localparam int PN_W    = 5;

   localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;
   localparam logic [OUT_W-1:0]   SAT_VALUE     = 20'hFFFFF;

   typedef enum logic [1:0] {
      PHASE_LOAD,
      PHASE_DIVIDE,
      PHASE_SWEEP,
      PHASE_EMIT
   } phase_type;

   // one-hot in practice: at most one of these is high in a cycle
   typedef struct packed {
      logic load;
      logic div_step;
      logic finish;
      logic sweep;
      logic shift_out;
   } cell_ctrl_type;

   // burst and round count of one process, circulated round the ring
   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] rounds;
   } token_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic               last_item;
   } req_payload_type;

   typedef struct packed {
      logic [PN_W-1:0]  process_number;
      logic [OUT_W-1:0] wait_time;
      logic [OUT_W-1:0] turnaround_time;
      logic             last_result;
   } rsp_payload_type;

endpackage

// File: src/rrwt_stream_if.sv
`timescale 1ns / 1ps

interface rrwt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/rrwt_cell.sv
`timescale 1ns / 1ps

module rrwt_cell
   import rrwt_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   parameter int CELL_INDEX    = 0,
   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1),
   localparam int AW    = BURST_W + $clog2(MAX_PROCESSES)
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [BURST_W-1:0] quantum,
   input  logic [CNT_W-1:0]   batch_count,
   input  logic [IDX_W-1:0]   load_slot,
   input  logic [IDX_W-1:0]   sweep_step,
   input  logic [BURST_W-1:0] load_burst,
   input  token_type          tok_prev,
   output token_type          tok_out,
   input  logic [AW-1:0]      acc_nbr,
   input  logic [BURST_W-1:0] burst_nbr,
   output logic [AW-1:0]      acc_out,
   output logic [BURST_W-1:0] burst_out
);

   localparam logic [IDX_W-1:0] OWN = IDX_W'(CELL_INDEX);

   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [BURST_W-1:0] quo_ff, quo_in;
   logic [BURST_W-1:0] rem_ff, rem_in;
   logic [BURST_W-1:0] k_ff, k_in;
   logic [BURST_W:0]   r_ff, r_in;
   logic [AW-1:0]      acc_ff, acc_in;
   token_type          tok_ff, tok_in;

   logic [BURST_W:0]   trial;
   logic [BURST_W:0]   q_ext;
   logic [BURST_W-1:0] k_calc;
   logic [BURST_W:0]   r_calc;
   logic [IDX_W:0]     wrap_idx;
   logic [IDX_W-1:0]   tok_idx;
   logic               tok_live;
   logic [BURST_W:0]   add;

   always_comb begin
      q_ext = {1'b0, quantum};
      trial = {rem_ff, quo_ff[BURST_W-1]};

      // ceiling of burst over quantum, and that many quanta of time
      k_calc = quo_ff + BURST_W'(rem_ff != '0);
      if (rem_ff == '0) begin
         r_calc = {1'b0, burst_ff};
      end else begin
         r_calc = {1'b0, burst_ff} - {1'b0, rem_ff} + q_ext;
      end

      // the token now held came from the cell sweep_step places upstream
      wrap_idx = (IDX_W + 1)'(MAX_PROCESSES + CELL_INDEX) - {1'b0, sweep_step};
      if (OWN >= sweep_step) begin
         tok_idx = OWN - sweep_step;
      end else begin
         tok_idx = wrap_idx[IDX_W-1:0];
      end
      tok_live = (CNT_W'(tok_idx) < batch_count) && (tok_idx != OWN) && (burst_ff != '0);

      // work the other process gets done before this one finishes
      if (tok_idx < OWN) begin
         add = (tok_ff.rounds <= k_ff) ? {1'b0, tok_ff.burst} : r_ff;
      end else begin
         add = (tok_ff.rounds < k_ff) ? {1'b0, tok_ff.burst} : r_ff - q_ext;
      end

      burst_in = burst_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      tok_in   = tok_ff;

      if (ctrl.load && load_slot == OWN) begin
         burst_in = load_burst;
         quo_in   = load_burst;
         rem_in   = '0;
      end
      if (ctrl.div_step) begin
         if (trial >= q_ext) begin
            rem_in = BURST_W'(trial - q_ext);
            quo_in = {quo_ff[BURST_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BURST_W-1:0];
            quo_in = {quo_ff[BURST_W-2:0], 1'b0};
         end
      end
      if (ctrl.finish) begin
         k_in          = k_calc;
         r_in          = r_calc;
         acc_in        = '0;
         tok_in.burst  = burst_ff;
         tok_in.rounds = k_calc;
      end
      if (ctrl.sweep) begin
         tok_in = tok_prev;
         if (tok_live) begin
            acc_in = acc_ff + AW'(add);
         end
      end
      if (ctrl.shift_out) begin
         acc_in   = acc_nbr;
         burst_in = burst_nbr;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      acc_ff   <= acc_in;
      tok_ff   <= tok_in;
   end

   assign tok_out   = tok_ff;
   assign acc_out   = acc_ff;
   assign burst_out = burst_ff;

endmodule

// File: src/rrwt_ctrl.sv
`timescale 1ns / 1ps

module rrwt_ctrl
   import rrwt_pkg::*;
#(
   parameter int MAX_PROCESSES = 16,
   localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
   localparam int CNT_W  = $clog2(MAX_PROCESSES + 1),
   localparam int STEP_W = $clog2(((MAX_PROCESSES > BURST_W) ? MAX_PROCESSES : BURST_W) + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_last,
   output cell_ctrl_type    cell_ctrl,
   output logic [IDX_W-1:0] load_slot,
   output logic [IDX_W-1:0] sweep_step,
   output logic [IDX_W-1:0] emit_index,
   output logic [CNT_W-1:0] batch_count
);

   phase_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              req_xfer;
   logic              rsp_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PHASE_LOAD;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      req_ready = (state_ff == PHASE_LOAD);
      rsp_valid = (state_ff == PHASE_EMIT);
      req_xfer  = req_valid && req_ready;
      rsp_xfer  = rsp_valid && rsp_ready;
      rsp_last  = ((step_ff + STEP_W'(1)) == STEP_W'(count_ff));

      cell_ctrl.load      = req_xfer && (count_ff < CNT_W'(MAX_PROCESSES));
      cell_ctrl.div_step  = (state_ff == PHASE_DIVIDE) && (step_ff < STEP_W'(BURST_W));
      cell_ctrl.finish    = (state_ff == PHASE_DIVIDE) && (step_ff == STEP_W'(BURST_W));
      cell_ctrl.sweep     = (state_ff == PHASE_SWEEP);
      cell_ctrl.shift_out = rsp_xfer;

      load_slot   = count_ff[IDX_W-1:0];
      sweep_step  = step_ff[IDX_W-1:0];
      emit_index  = step_ff[IDX_W-1:0];
      batch_count = count_ff;

      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;

      case (state_ff)
         PHASE_LOAD: begin
            if (req_xfer) begin
               // a transfer beyond the table is dropped but its mark still counts
               if (cell_ctrl.load) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = PHASE_DIVIDE;
                  step_in  = '0;
               end
            end
         end
         PHASE_DIVIDE: begin
            if (step_ff == STEP_W'(BURST_W)) begin
               state_in = PHASE_SWEEP;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         PHASE_SWEEP: begin
            if (step_ff == STEP_W'(MAX_PROCESSES - 1)) begin
               state_in = PHASE_EMIT;
               step_in  = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         PHASE_EMIT: begin
            if (rsp_xfer) begin
               if (rsp_last) begin
                  state_in = PHASE_LOAD;
                  step_in  = '0;
                  count_in = '0;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = PHASE_LOAD;
            step_in  = '0;
            count_in = '0;
         end
      endcase
   end

endmodule

// File: src/round_robin_waiting_time.sv
// bursts load at one transfer per cycle; the item carrying the last mark ends the batch
// after it: bit-serial division in every cell, then a sweep while the round-count
// tokens circulate once round the ring of cells
// results then leave cell 0 at one per cycle when not stalled, n for n loaded processes
// no request is taken from the last mark until the final result is transferred
// reset returns to loading with an empty table and quantum 4; cell storage is not cleared
`timescale 1ns / 1ps

module round_robin_waiting_time
   import rrwt_pkg::*;
#(
   parameter int MAX_PROCESSES = 16
) (
   input  logic          clock,
   input  logic          reset,
   rrwt_stream_if.sink   req_chan,
   rrwt_stream_if.source rsp_chan,
   rrwt_stream_if.sink   csr_chan
);

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int AW    = BURST_W + $clog2(MAX_PROCESSES);
   localparam int SW    = (AW + 1 > OUT_W + 1) ? AW + 1 : OUT_W + 1;

   logic [BURST_W-1:0] quantum_ff;
   logic [BURST_W-1:0] quantum_eff;

   cell_ctrl_type      cell_ctrl;
   logic [IDX_W-1:0]   load_slot;
   logic [IDX_W-1:0]   sweep_step;
   logic [IDX_W-1:0]   emit_index;
   logic [CNT_W-1:0]   batch_count;
   logic               rsp_last;

   token_type          tok_w   [MAX_PROCESSES];
   logic [AW-1:0]      acc_w   [MAX_PROCESSES];
   logic [BURST_W-1:0] burst_w [MAX_PROCESSES];

   logic [SW-1:0]      wait_ext;
   logic [SW-1:0]      turn_ext;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_chan.valid) begin
         quantum_ff <= csr_chan.data;
      end
   end

   // a zero quantum runs as one
   assign quantum_eff = (quantum_ff == '0) ? BURST_W'(1) : quantum_ff;

   rrwt_ctrl #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_last    (req_chan.data.last_item),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_last    (rsp_last),
      .cell_ctrl   (cell_ctrl),
      .load_slot   (load_slot),
      .sweep_step  (sweep_step),
      .emit_index  (emit_index),
      .batch_count (batch_count)
   );

   for (genvar i = 0; i < MAX_PROCESSES; i++) begin : g_cell
      logic [AW-1:0]      acc_next;
      logic [BURST_W-1:0] burst_next;

      if (i == MAX_PROCESSES - 1) begin : g_end
         assign acc_next   = '0;
         assign burst_next = '0;
      end else begin : g_mid
         assign acc_next   = acc_w[i+1];
         assign burst_next = burst_w[i+1];
      end

      rrwt_cell #(
         .MAX_PROCESSES (MAX_PROCESSES),
         .CELL_INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .quantum     (quantum_eff),
         .batch_count (batch_count),
         .load_slot   (load_slot),
         .sweep_step  (sweep_step),
         .load_burst  (req_chan.data.burst_time),
         .tok_prev    (tok_w[(i + MAX_PROCESSES - 1) % MAX_PROCESSES]),
         .tok_out     (tok_w[i]),
         .acc_nbr     (acc_next),
         .burst_nbr   (burst_next),
         .acc_out     (acc_w[i]),
         .burst_out   (burst_w[i])
      );
   end

   always_comb begin
      wait_ext = SW'(acc_w[0]);
      turn_ext = SW'(acc_w[0]) + SW'(burst_w[0]);

      rsp_chan.data.process_number = PN_W'(emit_index) + PN_W'(1);
      rsp_chan.data.wait_time =
         (wait_ext > SW'(SAT_VALUE)) ? SAT_VALUE : wait_ext[OUT_W-1:0];
      rsp_chan.data.turnaround_time =
         (turn_ext > SW'(SAT_VALUE)) ? SAT_VALUE : turn_ext[OUT_W-1:0];
      rsp_chan.data.last_result = rsp_last;
   end

endmodule

// File: src/rrwt_checker.sv
`timescale 1ns / 1ps

module rrwt_checker
   import rrwt_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_last,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PN_W-1:0]  rsp_pn,
   input logic [OUT_W-1:0] rsp_wait,
   input logic [OUT_W-1:0] rsp_turn,
   input logic             rsp_last
);

   // no request is taken while results are being drained
   a_no_req_during_emit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while results pending");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pn) && $stable(rsp_wait)
         && $stable(rsp_turn) && $stable(rsp_last))
      else $error("stalled result changed");

   a_end_of_batch : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result after the final one of a batch");

   a_last_closes_load : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("still loading after the last-item transfer");

   a_pn_sequence : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_pn == PN_W'($past(rsp_pn) + PN_W'(1))))
      else $error("process number out of sequence");

endmodule

bind round_robin_waiting_time rrwt_checker u_rrwt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.data.last_item),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pn    (rsp_chan.data.process_number),
   .rsp_wait  (rsp_chan.data.wait_time),
   .rsp_turn  (rsp_chan.data.turnaround_time),
   .rsp_last  (rsp_chan.data.last_result)
);

// File: verif/tb_round_robin_waiting_time.sv
`timescale 1ns / 1ps

module tb_round_robin_waiting_time;
   import rrwt_pkg::*;

   localparam int TABLE_DEPTH      = 16;
   localparam int SETTLE_CYCLES    = 48;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int ITEMS_PER_PHASE  = 36;
   localparam int REPORT_LIMIT     = 10;

   typedef enum logic [1:0] {
      STIM_BURST,
      STIM_QUANTUM,
      STIM_SETTLE,
      STIM_PACE
   } stim_kind_type;

   typedef struct {
      stim_kind_type      kind;
      logic [BURST_W-1:0] value;
      logic               last;
      int unsigned        idle_pct;
      int unsigned        stall_pct;
   } stim_type;

   logic clock;
   logic reset;

   rrwt_stream_if #(.payload_type(req_payload_type))    req_if ();
   rrwt_stream_if #(.payload_type(rsp_payload_type))    rsp_if ();
   rrwt_stream_if #(.payload_type(logic [BURST_W-1:0])) csr_if ();

   round_robin_waiting_time #(
      .MAX_PROCESSES(TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   stim_type           burst_feed [$];
   rsp_payload_type    due_reports [$];
   logic [BURST_W-1:0] batch_burst [TABLE_DEPTH];
   int                 loaded;
   logic [BURST_W-1:0] active_quantum;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   int unsigned        settle_cycles;
   int unsigned        idle_cycles;
   int unsigned        mismatches;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // round-robin over the loaded batch; whole rounds where every live process
   // takes a full slice are skipped in one go
   function automatic void predict_waits(input int count, input logic [BURST_W-1:0] quantum);
      longint unsigned left [TABLE_DEPTH];
      longint unsigned waited [TABLE_DEPTH];
      longint unsigned q;
      longint unsigned k;
      longint unsigned least;
      longint unsigned slice;
      longint unsigned turn;
      int              active;
      rsp_payload_type rep;
      q = (quantum == '0) ? 1 : quantum;
      for (int i = 0; i < count; i++) begin
         left[i]   = batch_burst[i];
         waited[i] = 0;
      end
      while (1) begin
         active = 0;
         least  = 0;
         for (int i = 0; i < count; i++) begin
            if (left[i] > 0) begin
               if (active == 0 || left[i] < least) begin
                  least = left[i];
               end
               active++;
            end
         end
         if (active == 0) begin
            break;
         end
         k = (least - 1) / q;
         if (k > 0) begin
            for (int i = 0; i < count; i++) begin
               if (left[i] > 0) begin
                  waited[i] += (active - 1) * q * k;
                  left[i]   -= k * q;
               end
            end
         end
         for (int i = 0; i < count; i++) begin
            if (left[i] != 0) begin
               slice = (left[i] > q) ? q : left[i];
               for (int j = 0; j < count; j++) begin
                  if (j != i && left[j] > 0) begin
                     waited[j] += slice;
                  end
               end
               left[i] -= slice;
            end
         end
      end
      for (int i = 0; i < count; i++) begin
         turn = waited[i] + batch_burst[i];
         rep.process_number  = PN_W'(i + 1);
         rep.wait_time       = (waited[i] > SAT_VALUE) ? SAT_VALUE : waited[i][OUT_W-1:0];
         rep.turnaround_time = (turn > SAT_VALUE) ? SAT_VALUE : turn[OUT_W-1:0];
         rep.last_result     = (i == count - 1);
         due_reports.push_back(rep);
      end
   endfunction

   function automatic logic [BURST_W-1:0] random_burst();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1, 2, 3: begin
            return BURST_W'($urandom_range(1, 12));
         end
         4: begin
            return BURST_W'($urandom_range(13, 300));
         end
         7: begin
            return BURST_W'(65535 - $urandom_range(0, 3));
         end
         default: begin
            return BURST_W'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   task automatic queue_burst(input logic [BURST_W-1:0] value, input logic last);
      stim_type s;
      s = '{kind: STIM_BURST, value: value, last: last, idle_pct: 0, stall_pct: 0};
      burst_feed.push_back(s);
   endtask

   task automatic queue_quantum(input logic [BURST_W-1:0] value);
      stim_type s;
      s = '{kind: STIM_QUANTUM, value: value, last: 1'b0, idle_pct: 0, stall_pct: 0};
      burst_feed.push_back(s);
   endtask

   task automatic queue_settle();
      stim_type s;
      s = '{kind: STIM_SETTLE, value: '0, last: 1'b0, idle_pct: 0, stall_pct: 0};
      burst_feed.push_back(s);
   endtask

   task automatic queue_pace(input int unsigned idle, input int unsigned stall);
      stim_type s;
      s = '{kind: STIM_PACE, value: '0, last: 1'b0, idle_pct: idle, stall_pct: stall};
      burst_feed.push_back(s);
   endtask

   // mostly batches that fit the table, now and then one that overflows it
   task automatic queue_random_batch(output int size);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4)
                                          : $urandom_range(1, TABLE_DEPTH);
      for (int i = 0; i < size; i++) begin
         queue_burst(random_burst(), i == size - 1);
      end
   endtask

   // sender: at most one step of the feed per cycle, once both channels are free
   always @(posedge clock) begin : feed
      stim_type        head;
      req_payload_type item;
      logic            req_free;
      logic            csr_free;
      logic            next_req_valid;
      logic            next_csr_valid;
      logic            quiet;
      logic            moved;
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.data   <= '0;
         csr_if.valid  <= 1'b0;
         csr_if.data   <= '0;
         settle_cycles <= 0;
         send_idle_pct = 0;
         stall_pct     <= 0;
      end else begin
         req_free       = !req_if.valid || req_if.ready;
         csr_free       = !csr_if.valid || csr_if.ready;
         next_req_valid = !req_free;
         next_csr_valid = !csr_free;
         quiet = !req_if.valid && !csr_if.valid && due_reports.size() == 0
                 && settle_cycles >= SETTLE_CYCLES;
         if (req_free && csr_free && burst_feed.size() > 0) begin
            head = burst_feed[0];
            case (head.kind)
               STIM_BURST: begin
                  if ($urandom_range(0, 99) >= send_idle_pct) begin
                     item.burst_time = head.value;
                     item.last_item  = head.last;
                     req_if.data    <= item;
                     next_req_valid  = 1'b1;
                     void'(burst_feed.pop_front());
                  end
               end
               STIM_QUANTUM: begin
                  if (quiet) begin
                     csr_if.data   <= head.value;
                     next_csr_valid = 1'b1;
                     void'(burst_feed.pop_front());
                  end
               end
               STIM_SETTLE: begin
                  if (quiet) begin
                     void'(burst_feed.pop_front());
                  end
               end
               STIM_PACE: begin
                  send_idle_pct = head.idle_pct;
                  stall_pct    <= head.stall_pct;
                  void'(burst_feed.pop_front());
               end
               default: begin
                  void'(burst_feed.pop_front());
               end
            endcase
         end
         req_if.valid <= next_req_valid;
         csr_if.valid <= next_csr_valid;
         moved = (req_if.valid && req_if.ready) || (csr_if.valid && csr_if.ready)
                 || (rsp_if.valid && rsp_if.ready);
         if (moved) begin
            settle_cycles <= 0;
         end else if (settle_cycles < SETTLE_CYCLES) begin
            settle_cycles <= settle_cycles + 1;
         end
      end
   end

   // receiver, predictor and checker
   always @(posedge clock) begin : observe
      rsp_payload_type got;
      rsp_payload_type want;
      logic            moved;
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         idle_cycles   <= 0;
         loaded         = 0;
         active_quantum = QUANTUM_RESET;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         if (csr_if.valid && csr_if.ready) begin
            active_quantum = csr_if.data;
         end
         if (req_if.valid && req_if.ready) begin
            if (loaded < TABLE_DEPTH) begin
               batch_burst[loaded] = req_if.data.burst_time;
               loaded++;
            end
            if (req_if.data.last_item) begin
               predict_waits(loaded, active_quantum);
               loaded = 0;
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (due_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected report: proc %0d wait %0d turnaround %0d last %0b",
                           got.process_number, got.wait_time, got.turnaround_time,
                           got.last_result);
               end
            end else begin
               want = due_reports.pop_front();
               if (got.process_number !== want.process_number
                   || got.wait_time !== want.wait_time
                   || got.turnaround_time !== want.turnaround_time
                   || got.last_result !== want.last_result) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("report mismatch: expected proc %0d wait %0d turnaround %0d last %0b",
                              want.process_number, want.wait_time, want.turnaround_time,
                              want.last_result);
                     $display("                 got      proc %0d wait %0d turnaround %0d last %0b",
                              got.process_number, got.wait_time, got.turnaround_time,
                              got.last_result);
                  end
               end
            end
         end
         moved = (req_if.valid && req_if.ready) || (csr_if.valid && csr_if.ready)
                 || (rsp_if.valid && rsp_if.ready);
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("[round_robin_waiting_time] ERROR");
      $finish;
   end

   initial begin : stimulus
      int size;
      int phase_items;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      rsp_if.ready = 1'b0;
      reset        = 1'b1;
      mismatches   = 0;
      idle_cycles  = 0;

      // reset quantum: lone zero burst, then extremes, exact multiples and a zero
      queue_burst(16'd0, 1'b1);
      queue_burst(16'hFFFF, 1'b0);
      queue_burst(16'd0, 1'b0);
      queue_burst(16'd3, 1'b0);
      queue_burst(16'd8, 1'b0);
      queue_burst(16'd4, 1'b0);
      queue_burst(16'd1, 1'b1);
      // table overflow: two extra items dropped, the mark on the last still ends the batch
      for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
         queue_burst((i % 3 == 0) ? 16'hFFFF : random_burst(), i == TABLE_DEPTH + 1);
      end

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               queue_pace(0, 0);
               queue_quantum(16'd1);
            end
            1: begin
               queue_pace(81, 0);
               queue_quantum(16'hFFFF);
            end
            2: begin
               queue_pace(0, 81);
               // zero acts as a quantum of one
               queue_quantum(16'd0);
            end
            3: begin
               queue_pace(38, 38);
               queue_quantum(BURST_W'($urandom_range(2, 16)));
            end
            default: begin
               queue_pace(0, 0);
               queue_quantum(BURST_W'($urandom_range(1, 65535)));
            end
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            queue_random_batch(size);
            phase_items += size;
            if (phase_items == size) begin
               // hold the sender until the batch has fully drained
               queue_settle();
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (burst_feed.size() > 0 || req_if.valid || csr_if.valid || due_reports.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_reports.size() == 0) begin
         $display("[round_robin_waiting_time] OK");
      end else begin
         $display("[round_robin_waiting_time] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
src/rrwt_pkg.sv
src/rrwt_stream_if.sv
src/rrwt_cell.sv
src/rrwt_ctrl.sv
src/round_robin_waiting_time.sv
src/rrwt_checker.sv
verif/tb_round_robin_waiting_time.sv
